/* sv/tdma_node_slot_table_top_macros.svh */
// Assertion macros shared by the node table RTL.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef TDMA_NODE_SLOT_TABLE_TOP_MACROS_SVH
`define TDMA_NODE_SLOT_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge.
`define TDST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true at a clock edge.
`define TDST_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TDST_ASSERT(lbl, prop, msg)
`define TDST_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/tdst_pkg.sv */
`timescale 1ns / 1ps

package tdst_pkg;

    // Default sizing of the table.
    localparam int DEF_MAX_NODES = 16;
    localparam int DEF_MAX_SLOTS = 16;

    // At most this many results are produced for one tick or beacon.
    localparam int MAX_RESULTS = 16;

    // Reset value of the stale timeout, in milliseconds.
    localparam logic [31:0] DEF_STALE_TIMEOUT = 32'd30000;

    // Mask that keeps the low byte of a node id.
    localparam logic [7:0] LOW_BYTE_MASK = 8'hFF;

    // Stored slot field is wide enough for the largest slot count.
    localparam int SLOT_REC_W  = 6;
    localparam int SLOT_IDX_W  = 4;
    localparam int COUNT_OUT_W = 5;

    // Operation codes carried in the kind field.
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_UPDATE = 3'd2,
        OP_TICK   = 3'd3,
        OP_BEACON = 3'd4
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SLOT,
        S_FINISH,
        S_TRD,
        S_TOUT,
        S_BRD,
        S_BOUT
    } state_t;

    // One table entry as kept in the entry memory.
    typedef struct packed {
        logic [15:0]           id;
        logic [7:0]            node_type;
        logic [SLOT_REC_W-1:0] slot;
        logic [7:0]            strength;
        logic [31:0]           seen_time;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic                   ok;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic                   slot_valid;
        logic [15:0]            removed_id;
        logic [7:0]             owner_low_byte;
        logic [31:0]            beacon_time;
        logic [COUNT_OUT_W-1:0] active_count;
        logic                   last;
    } result_t;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic id_eq;
        logic stale;
    } cmp_t;

endpackage

/* sv/tdst_cmp_unit.sv */
`timescale 1ns / 1ps

module tdst_cmp_unit
    import tdst_pkg::*;
(
    input  logic [15:0] rec_id,
    input  logic [31:0] rec_seen_time,
    input  logic [15:0] key_id,
    input  logic [31:0] now_time,
    input  logic [31:0] timeout,
    output cmp_t        flags
);

    logic [31:0] age;

    // Wrapping age of the entry, compared against the timeout.
    assign age = now_time - rec_seen_time;

    assign flags.stale = (age > timeout);
    assign flags.id_eq = (rec_id == key_id);

endmodule

/* sv/tdma_node_slot_table_top.sv */
`timescale 1ns / 1ps
// Sequence: add, remove and update scan every entry, and a new add then searches the slots
// for a free one; tick scans and then reports each removed entry, skipping the others;
// beacon scans and then reports min(MAX_SLOTS, 16) slots in turn, each after its owner read.
// One item at a time: every entry passes in turn through one compare unit behind a
// registered memory read port, and the slot search steps one slot per cycle.
// Reset (rst_n, asynchronous, active low) empties the table and loads the 30000 ms timeout.
`include "tdma_node_slot_table_top_macros.svh"

module tdma_node_slot_table_top
    import tdst_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    // Input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             kind,
    input  logic [15:0]            node_id,
    input  logic [7:0]             node_type,
    input  logic signed [7:0]      signal_strength,
    input  logic [31:0]            now_ms,
    // Output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   ok,
    output logic [SLOT_IDX_W-1:0]  slot_index,
    output logic                   slot_valid,
    output logic [15:0]            removed_id,
    output logic [7:0]             owner_low_byte,
    output logic [31:0]            beacon_time,
    output logic [COUNT_OUT_W-1:0] active_count,
    output logic                   last
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int EW = $clog2(MAX_RESULTS);
    localparam int NB = (MAX_SLOTS < MAX_RESULTS) ? MAX_SLOTS : MAX_RESULTS;

    state_t                state_reg, state_next;

    // Control state
    logic [31:0]           stale_timeout_reg;
    logic [MAX_NODES-1:0]  active_reg;
    logic [CW-1:0]         count_reg;
    logic                  out_valid_reg;
    logic [CW-1:0]         iss_reg;
    logic                  pvld_reg;
    logic                  hit_reg;
    logic                  free_found_reg;
    logic [MAX_NODES-1:0]  gone_reg;
    logic [MAX_SLOTS-1:0]  slot_bits_reg;
    logic [SW-1:0]         sidx_reg;
    logic [EW-1:0]         ecnt_reg;

    // Item and working data
    op_t                   op_reg;
    logic [15:0]           id_reg;
    logic [7:0]            type_reg;
    logic [7:0]            strength_reg;
    logic [31:0]           now_reg;
    logic [IW-1:0]         pidx_reg;
    logic [IW-1:0]         hit_idx_reg;
    entry_t                hit_rec_reg;
    logic [IW-1:0]         free_idx_reg;
    logic [SLOT_REC_W-1:0] new_slot_reg;
    logic                  new_sv_reg;
    logic [MAX_NODES-1:0]  slot_valid_bits_reg;
    result_t               res_reg;

    // Memories
    entry_t                entry_mem_reg [MAX_NODES];
    logic [7:0]            owner_mem_reg [MAX_SLOTS];
    entry_t                rd_rec_reg;
    logic [7:0]            owner_rd_reg;

    // Combinational
    cmp_t                  cmp_flags;
    logic                  out_free;
    logic                  push;
    result_t               res_next;
    result_t               fin_res;
    result_t               tick_res;
    result_t               beacon_res;
    logic                  scan_done;
    logic                  cur_active;
    logic                  cur_sv;
    logic                  add_new;
    logic                  higher_any;
    logic                  tick_last;
    logic                  beacon_last;
    logic [SLOT_REC_W-1:0] sidx_wide;
    logic [CW-1:0]         count_inc;
    logic [CW-1:0]         count_dec;

    // Shared compare unit: id match and stale test for the entry at the read port.
    tdst_cmp_unit u_cmp (
        .rec_id        (rd_rec_reg.id),
        .rec_seen_time (rd_rec_reg.seen_time),
        .key_id        (id_reg),
        .now_time      (now_reg),
        .timeout       (stale_timeout_reg),
        .flags         (cmp_flags)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign scan_done   = (iss_reg == CW'(MAX_NODES)) && !pvld_reg;
    assign cur_active  = active_reg[pidx_reg];
    assign cur_sv      = slot_valid_bits_reg[pidx_reg];
    assign add_new     = (op_reg == OP_ADD) && !hit_reg && free_found_reg;
    assign sidx_wide   = SLOT_REC_W'(sidx_reg);
    assign count_inc   = CW'(count_reg + 1'b1);
    assign count_dec   = CW'(count_reg - 1'b1);
    assign beacon_last = (sidx_reg == SW'(NB - 1));

    // Output fields come straight from the result register.
    assign ok             = res_reg.ok;
    assign slot_index     = res_reg.slot_index;
    assign slot_valid     = res_reg.slot_valid;
    assign removed_id     = res_reg.removed_id;
    assign owner_low_byte = res_reg.owner_low_byte;
    assign beacon_time    = res_reg.beacon_time;
    assign active_count   = res_reg.active_count;
    assign last           = res_reg.last;

    // Any removed entry beyond the one being reported ends the tick run later.
    always_comb
    begin
        higher_any = 1'b0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (gone_reg[i] && (CW'(i) > iss_reg))
            begin
                higher_any = 1'b1;
            end
        end
    end

    assign tick_last = (ecnt_reg == EW'(MAX_RESULTS - 1)) || !higher_any;

    // Single result of add, remove, update, or a tick that removed nothing.
    always_comb
    begin
        fin_res              = '0;
        fin_res.last         = 1'b1;
        fin_res.active_count = COUNT_OUT_W'(count_reg);
        case (op_reg)
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    fin_res.ok         = 1'b1;
                    fin_res.slot_index = hit_rec_reg.slot[SLOT_IDX_W-1:0];
                    fin_res.slot_valid = slot_valid_bits_reg[hit_idx_reg];
                end
                else if (free_found_reg)
                begin
                    fin_res.ok           = 1'b1;
                    fin_res.slot_index   = new_slot_reg[SLOT_IDX_W-1:0];
                    fin_res.slot_valid   = new_sv_reg;
                    fin_res.active_count = COUNT_OUT_W'(count_inc);
                end
            end
            OP_REMOVE:
            begin
                fin_res.ok = hit_reg;
                if (hit_reg)
                begin
                    fin_res.active_count = COUNT_OUT_W'(count_dec);
                end
            end
            OP_UPDATE:
            begin
                fin_res.ok = hit_reg;
            end
            default:
            begin
                fin_res.ok = 1'b0;
            end
        endcase
    end

    // Result for one removed entry of a tick.
    always_comb
    begin
        tick_res              = '0;
        tick_res.ok           = 1'b1;
        tick_res.removed_id   = rd_rec_reg.id;
        tick_res.active_count = COUNT_OUT_W'(count_reg);
        tick_res.last         = tick_last;
    end

    // Result for one slot of a beacon.
    always_comb
    begin
        beacon_res                = '0;
        beacon_res.ok             = 1'b1;
        beacon_res.slot_index     = sidx_wide[SLOT_IDX_W-1:0];
        beacon_res.slot_valid     = slot_bits_reg[sidx_reg];
        beacon_res.owner_low_byte = slot_bits_reg[sidx_reg] ?
                                    (owner_rd_reg & LOW_BYTE_MASK) : 8'd0;
        beacon_res.beacon_time    = now_reg;
        beacon_res.active_count   = COUNT_OUT_W'(count_reg);
        beacon_res.last           = beacon_last;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and result transfer into the output register.
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        res_next   = fin_res;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind) inside
                        OP_ADD, OP_REMOVE, OP_UPDATE, OP_TICK, OP_BEACON:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            state_next = (hit_reg || !free_found_reg) ? S_FINISH : S_SLOT;
                        end
                        OP_TICK:
                        begin
                            state_next = (gone_reg == '0) ? S_FINISH : S_TRD;
                        end
                        OP_BEACON:
                        begin
                            state_next = S_BRD;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                if (!slot_bits_reg[sidx_reg] || (sidx_reg == SW'(MAX_SLOTS - 1)))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                if (gone_reg[iss_reg[IW-1:0]])
                begin
                    state_next = S_TOUT;
                end
            end
            S_TOUT:
            begin
                res_next = tick_res;
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = tick_last ? S_IDLE : S_TRD;
                end
            end
            S_BRD:
            begin
                state_next = S_BOUT;
            end
            S_BOUT:
            begin
                res_next = beacon_res;
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = beacon_last ? S_IDLE : S_BRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers: table occupancy, counters and scan flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= DEF_STALE_TIMEOUT;
            active_reg        <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            iss_reg           <= '0;
            pvld_reg          <= 1'b0;
            hit_reg           <= 1'b0;
            free_found_reg    <= 1'b0;
            gone_reg          <= '0;
            slot_bits_reg     <= '0;
            sidx_reg          <= '0;
            ecnt_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                stale_timeout_reg <= cfg_wdata;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        iss_reg        <= '0;
                        pvld_reg       <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        gone_reg       <= '0;
                        slot_bits_reg  <= '0;
                    end
                end
                S_SCAN:
                begin
                    // Issue one entry read per cycle, evaluate it the cycle after.
                    if (iss_reg != CW'(MAX_NODES))
                    begin
                        iss_reg  <= CW'(iss_reg + 1'b1);
                        pvld_reg <= 1'b1;
                    end
                    else
                    begin
                        pvld_reg <= 1'b0;
                    end

                    if (pvld_reg)
                    begin
                        case (op_reg)
                            OP_ADD:
                            begin
                                if (cur_active && cmp_flags.id_eq)
                                begin
                                    hit_reg <= 1'b1;
                                end
                                if (!cur_active)
                                begin
                                    free_found_reg <= 1'b1;
                                end
                                if (cur_active && cur_sv)
                                begin
                                    slot_bits_reg[rd_rec_reg.slot[SW-1:0]] <= 1'b1;
                                end
                            end
                            OP_REMOVE, OP_UPDATE:
                            begin
                                if (cur_active && cmp_flags.id_eq)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            OP_TICK:
                            begin
                                if (cur_active && cmp_flags.stale)
                                begin
                                    active_reg[pidx_reg] <= 1'b0;
                                    gone_reg[pidx_reg]   <= 1'b1;
                                    count_reg            <= count_dec;
                                end
                            end
                            OP_BEACON:
                            begin
                                if (cur_active && cur_sv)
                                begin
                                    slot_bits_reg[rd_rec_reg.slot[SW-1:0]] <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    // Set up the follow-on phase.
                    if (scan_done)
                    begin
                        iss_reg  <= '0;
                        ecnt_reg <= '0;
                        sidx_reg <= (op_reg == OP_BEACON) ? SW'(0) : SW'(1);
                    end
                end
                S_SLOT:
                begin
                    if (slot_bits_reg[sidx_reg] && (sidx_reg != SW'(MAX_SLOTS - 1)))
                    begin
                        sidx_reg <= SW'(sidx_reg + 1'b1);
                    end
                end
                S_FINISH:
                begin
                    if (push)
                    begin
                        if (add_new)
                        begin
                            active_reg[free_idx_reg] <= 1'b1;
                            count_reg                <= count_inc;
                        end
                        else if ((op_reg == OP_REMOVE) && hit_reg)
                        begin
                            active_reg[hit_idx_reg] <= 1'b0;
                            count_reg               <= count_dec;
                        end
                    end
                end
                S_TRD:
                begin
                    if (!gone_reg[iss_reg[IW-1:0]])
                    begin
                        iss_reg <= CW'(iss_reg + 1'b1);
                    end
                end
                S_TOUT:
                begin
                    if (push && !tick_last)
                    begin
                        ecnt_reg <= EW'(ecnt_reg + 1'b1);
                        iss_reg  <= CW'(iss_reg + 1'b1);
                    end
                end
                S_BOUT:
                begin
                    if (push && !beacon_last)
                    begin
                        sidx_reg <= SW'(sidx_reg + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working data, memories and the result register.
    always_ff @(posedge clk)
    begin
        rd_rec_reg   <= entry_mem_reg[iss_reg[IW-1:0]];
        owner_rd_reg <= owner_mem_reg[sidx_reg];

        if (push)
        begin
            res_reg <= res_next;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg       <= op_t'(kind);
                    id_reg       <= node_id;
                    type_reg     <= node_type;
                    strength_reg <= $unsigned(signal_strength);
                    now_reg      <= now_ms;
                end
            end
            S_SCAN:
            begin
                if (iss_reg != CW'(MAX_NODES))
                begin
                    pidx_reg <= iss_reg[IW-1:0];
                end
                if (pvld_reg)
                begin
                    // Lowest matching entry and lowest free entry.
                    if (cur_active && cmp_flags.id_eq && !hit_reg)
                    begin
                        hit_idx_reg <= pidx_reg;
                        hit_rec_reg <= rd_rec_reg;
                    end
                    if (!cur_active && !free_found_reg)
                    begin
                        free_idx_reg <= pidx_reg;
                    end
                    // Later entries overwrite, so the highest index owns a shared slot.
                    if ((op_reg == OP_BEACON) && cur_active && cur_sv)
                    begin
                        owner_mem_reg[rd_rec_reg.slot[SW-1:0]] <= rd_rec_reg.id[7:0];
                    end
                end
            end
            S_SLOT:
            begin
                new_sv_reg   <= !slot_bits_reg[sidx_reg];
                new_slot_reg <= slot_bits_reg[sidx_reg] ? '0 : sidx_wide;
            end
            S_FINISH:
            begin
                if (push)
                begin
                    if (add_new)
                    begin
                        entry_mem_reg[free_idx_reg]       <= '{id:        id_reg,
                                                               node_type: type_reg,
                                                               slot:      new_slot_reg,
                                                               strength:  8'd0,
                                                               seen_time: now_reg};
                        slot_valid_bits_reg[free_idx_reg] <= new_sv_reg;
                    end
                    else if ((op_reg == OP_UPDATE) && hit_reg)
                    begin
                        entry_mem_reg[hit_idx_reg] <= '{id:        hit_rec_reg.id,
                                                         node_type: hit_rec_reg.node_type,
                                                         slot:      hit_rec_reg.slot,
                                                         strength:  strength_reg,
                                                         seen_time: now_reg};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Checks on the sequencer and table bookkeeping.
    `TDST_ASSERT(a_count_matches_active, $countones(active_reg) == int'(count_reg), "active count out of step with entries")
    `TDST_ASSERT(a_accept_starts_scan, (in_valid && in_ready && (kind <= OP_BEACON)) |=> (state_reg == S_SCAN), "known operation did not start a scan")
    `TDST_NEVER(a_slot_search_skips_beacon, (state_reg == S_SLOT) && (sidx_reg == '0), "slot search reached the beacon slot")
    `TDST_NEVER(a_tick_emit_has_removal, ((state_reg == S_TRD) || (state_reg == S_TOUT)) && (gone_reg == '0), "tick report with no removed entry")
    `TDST_NEVER(a_no_result_overwrite, push && out_valid_reg && !out_ready, "result overwrote a pending transfer")

endmodule
